// ----- sv/trce_pkg.sv -----
// shared types and constants for the tri-state remote code encoder
`timescale 1ns / 1ps
`default_nettype none

package trce_pkg;

    localparam int CODES_W  = 24;
    localparam int PERIOD_W = 10;
    localparam int DUR_W    = 17;
    localparam int CLK_W    = 7;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd100;

    localparam logic [CLK_W-1:0] CLK_SHORT    = 7'd4;
    localparam logic [CLK_W-1:0] CLK_LONG     = 7'(16 - 4);
    localparam logic [CLK_W-1:0] CLK_SYNC_LOW = 7'(128 - 4);

    localparam logic [1:0] CODE_LOW   = 2'd0;
    localparam logic [1:0] CODE_HIGH  = 2'd1;
    localparam logic [1:0] CODE_FLOAT = 2'd2;
    localparam logic [1:0] CODE_SKIP  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PINS,
        ST_SYNC_HI,
        ST_SYNC_LO
    } state_t;

    typedef enum logic [1:0] {
        SEG_PIN,
        SEG_SYNC_HI,
        SEG_SYNC_LO
    } seg_kind_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        logic      step;
        logic      skip;
        seg_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic code_skip;
        logic seg_last;
        logic pin_last;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ----- sv/trce_ctrl.sv -----
// sequencing state machine: walks pins, segments and the closing sync
`timescale 1ns / 1ps
`default_nettype none

module trce_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire trce_pkg::dp_sts_t sts,
    output trce_pkg::dp_cmd_t      cmd
);
    import trce_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{load: 1'b0, emit: 1'b0, step: 1'b0, skip: 1'b0, kind: SEG_PIN};
        in_stall   = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PINS;
                end
            end
            ST_PINS:
            begin
                if (sts.code_skip)
                begin
                    cmd.skip = 1'b1;
                    if (sts.pin_last)
                    begin
                        state_next = ST_SYNC_HI;
                    end
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.step = 1'b1;
                    if (sts.seg_last && sts.pin_last)
                    begin
                        state_next = ST_SYNC_HI;
                    end
                end
            end
            ST_SYNC_HI:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = SEG_SYNC_HI;
                    state_next = ST_SYNC_LO;
                end
            end
            ST_SYNC_LO:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = SEG_SYNC_LO;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("segment issued while output register is full");

    a_sync_lo_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SYNC_LO) && sts.out_free |=> state_reg == ST_IDLE)
        else $error("sync low segment did not close the packet");

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_PINS)
        else $error("packet load did not start pin walk");

endmodule

`default_nettype wire

// ----- sv/trce_dp.sv -----
// datapath: period register, pin code shifter, counters, duration product, output register
`timescale 1ns / 1ps
`default_nettype none

module trce_dp #(
    parameter int NUM_PINS = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [trce_pkg::PERIOD_W-1:0]   cfg_wr_data,
    input  wire logic [trce_pkg::CODES_W-1:0]    pin_codes,
    input  wire trce_pkg::dp_cmd_t               cmd,
    output trce_pkg::dp_sts_t                    sts,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 line_level,
    output logic [trce_pkg::DUR_W-1:0]           duration_us,
    output logic                                 last_segment
);
    import trce_pkg::*;

    localparam int PIN_W   = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam int SHIFT_W = 2 * NUM_PINS;

    logic [PERIOD_W-1:0] period_reg;
    logic [SHIFT_W-1:0]  codes_reg;
    logic [SHIFT_W-1:0]  codes_next;
    logic [PIN_W-1:0]    pin_reg;
    logic [PIN_W-1:0]    pin_next;
    logic [1:0]          seg_reg;
    logic [1:0]          seg_next;
    logic                valid_reg;
    logic                valid_next;
    logic                level_reg;
    logic [DUR_W-1:0]    dur_reg;
    logic                last_reg;

    logic [1:0]       code;
    logic             long_first;
    logic             seg_level;
    logic [CLK_W-1:0] seg_clocks;
    logic             seg_last_flag;
    logic             pin_advance;

    assign code       = codes_reg[1:0];
    // float sends its first bit as low and its second as high
    assign long_first = (code == CODE_HIGH) || ((code == CODE_FLOAT) && seg_reg[1]);

    always_comb
    begin
        seg_level     = 1'b0;
        seg_clocks    = CLK_SHORT;
        seg_last_flag = 1'b0;
        case (cmd.kind)
            SEG_PIN:
            begin
                seg_level  = ~seg_reg[0];
                seg_clocks = (seg_level == long_first) ? CLK_LONG : CLK_SHORT;
            end
            SEG_SYNC_HI:
            begin
                seg_level  = 1'b1;
                seg_clocks = CLK_SHORT;
            end
            SEG_SYNC_LO:
            begin
                seg_level     = 1'b0;
                seg_clocks    = CLK_SYNC_LOW;
                seg_last_flag = 1'b1;
            end
            default:
            begin
                seg_level = 1'b0;
            end
        endcase
    end

    assign pin_advance = cmd.skip || (cmd.step && (seg_reg == 2'd3));

    always_comb
    begin
        codes_next = codes_reg;
        pin_next   = pin_reg;
        seg_next   = seg_reg;
        if (cmd.load)
        begin
            codes_next = pin_codes[SHIFT_W-1:0];
            pin_next   = '0;
            seg_next   = '0;
        end
        else
        begin
            if (cmd.step)
            begin
                seg_next = seg_reg + 2'd1;
            end
            if (pin_advance)
            begin
                codes_next = codes_reg >> 2;
                pin_next   = pin_reg + PIN_W'(1);
            end
        end
    end

    assign sts.code_skip = (code == CODE_SKIP);
    assign sts.seg_last  = (seg_reg == 2'd3);
    assign sts.pin_last  = (pin_reg == PIN_W'(NUM_PINS - 1));
    assign sts.out_free  = ~valid_reg | ~out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.emit)
        begin
            valid_next = 1'b1;
        end
        else if (~out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            pin_reg    <= '0;
            seg_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            pin_reg   <= pin_next;
            seg_reg   <= seg_next;
            valid_reg <= valid_next;
        end
    end

    // payload words carry no reset
    always_ff @(posedge clk)
    begin
        codes_reg <= codes_next;
        if (cmd.emit)
        begin
            level_reg <= seg_level;
            dur_reg   <= DUR_W'(period_reg) * DUR_W'(seg_clocks);
            last_reg  <= seg_last_flag;
        end
    end

    assign out_valid    = valid_reg;
    assign line_level   = level_reg;
    assign duration_us  = dur_reg;
    assign last_segment = last_reg;

    a_last_is_low: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && last_reg |-> !level_reg)
        else $error("closing word is not a low segment");

    a_emit_loads_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> valid_reg)
        else $error("issued segment did not reach the output register");

    a_skip_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.skip |-> !cmd.emit && !cmd.step)
        else $error("skipped pin produced a segment");

endmodule

`default_nettype wire

// ----- sv/tristate_remote_code_encoder.sv -----
// Tri-state remote code encoder top level.
// Input channel: one word is a packet of tri-state pin codes (pin_codes, two bits
// per pin, pin 0 in bits 1:0). Output channel: one word per line segment, giving
// line_level, duration_us and last_segment, which marks the closing sync low.
// Each pin that is not skipped yields four segments; every packet ends with a
// sync high and a sync low segment, so 2 to 50 words per packet.
// The first word is registered on the output after the packet is accepted and
// the sequencer has entered its pin walk and passed any skipped pins ahead of
// the first segment. Throughput: the single segment sequencer issues at most
// one segment a cycle and is the limit. A new packet is taken once the last
// word has been issued, while that word may still wait in the output register.
// cfg_wr_en / cfg_wr_data write the oscillator period in microseconds; write
// it only while the block is idle.
// Reset sets the period to 100 and empties the output register.
// A stall on the output holds the current word; the sequencer waits at its next
// segment, while skipped pins still move on one a cycle.
`timescale 1ns / 1ps
`default_nettype none

module tristate_remote_code_encoder #(
    parameter int NUM_PINS = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [trce_pkg::PERIOD_W-1:0] cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [trce_pkg::CODES_W-1:0]  pin_codes,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               line_level,
    output logic [trce_pkg::DUR_W-1:0]         duration_us,
    output logic                               last_segment
);
    import trce_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    trce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    trce_dp #(
        .NUM_PINS (NUM_PINS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .pin_codes    (pin_codes),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_level   (line_level),
        .duration_us  (duration_us),
        .last_segment (last_segment)
    );

endmodule

`default_nettype wire

// ----- tb/tristate_remote_code_encoder_tb.sv -----
// self-checking testbench for the tri-state remote code encoder
`timescale 1ns / 1ps

module tristate_remote_code_encoder_tb;

    import trce_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 32;
    localparam int NUM_PHASES = 9;

    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] dur;
        logic             last;
    } segment_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [PERIOD_W-1:0] cfg_wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CODES_W-1:0]  pin_codes = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                line_level;
    logic [DUR_W-1:0]    duration_us;
    logic                last_segment;

    logic [PERIOD_W-1:0] period_us = PERIOD_RESET;
    logic [CODES_W-1:0]  pending_packets[$];
    segment_t            expected_segs[$];
    segment_t            want;
    int                  send_idle_pct = 8;
    int                  recv_stall_pct = 70;
    int                  fail_count = 0;
    int                  idle_cycles = 0;

    tristate_remote_code_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pin_codes    (pin_codes),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_level   (line_level),
        .duration_us  (duration_us),
        .last_segment (last_segment)
    );

    always #5 clk = ~clk;

    function automatic void push_segment(logic level, logic [CLK_W-1:0] clocks, logic last);
        int prod;
        prod = int'(period_us) * int'(clocks);
        expected_segs.push_back('{level, DUR_W'(prod), last});
    endfunction

    // one bit is a high pulse then a low pulse
    function automatic void push_bit(logic long_first);
        push_segment(1'b1, long_first ? CLK_LONG : CLK_SHORT, 1'b0);
        push_segment(1'b0, long_first ? CLK_SHORT : CLK_LONG, 1'b0);
    endfunction

    function automatic void encode_packet(logic [CODES_W-1:0] codes);
        logic [1:0] c;
        for (int i = 0; i < 12; i++) begin
            c = codes[2*i +: 2];
            case (c)
                CODE_LOW:
                begin
                    push_bit(1'b0);
                    push_bit(1'b0);
                end
                CODE_HIGH:
                begin
                    push_bit(1'b1);
                    push_bit(1'b1);
                end
                CODE_FLOAT:
                begin
                    push_bit(1'b0);
                    push_bit(1'b1);
                end
                default:
                begin
                end
            endcase
        end
        push_segment(1'b1, CLK_SHORT, 1'b0);
        push_segment(1'b0, CLK_SYNC_LOW, 1'b1);
    endfunction

    function automatic logic [CODES_W-1:0] random_packet();
        logic [CODES_W-1:0] codes;
        logic [1:0]         c;
        int                 style;
        style = $urandom_range(9);
        codes = CODES_W'($urandom());
        c = 2'($urandom_range(3));
        for (int i = 0; i < 12; i++) begin
            case (style)
                6: if ($urandom_range(3) != 0) codes[2*i +: 2] = CODE_SKIP;
                7: codes[2*i +: 2] = c;
                8: codes[2*i +: 2] = 2'($urandom_range(2));
                9: codes[2*i +: 2] = CODE_SKIP;
                default: ;
            endcase
        end
        return codes;
    endfunction

    // driver: the encoded segments are predicted when the packet is taken
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            pin_codes <= '0;
        end
        else begin
            if (in_valid && !in_stall)
                encode_packet(pin_codes);
            if (!in_valid || !in_stall) begin
                if (pending_packets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    pin_codes <= pending_packets.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_segs.size() == 0) begin
                    $error("segment with nothing expected: level %0d dur %0d last %0d",
                           line_level, duration_us, last_segment);
                    fail_count++;
                end
                else begin
                    want = expected_segs.pop_front();
                    if (line_level !== want.level) begin
                        $error("line_level: expected %0d, got %0d", want.level, line_level);
                        fail_count++;
                    end
                    if (duration_us !== want.dur) begin
                        $error("duration_us: expected %0d, got %0d", want.dur, duration_us);
                        fail_count++;
                    end
                    if (last_segment !== want.last) begin
                        $error("last_segment: expected %0d, got %0d", want.last, last_segment);
                        fail_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // checked on the falling edge so the driver and monitor have settled
    task automatic wait_drained();
        while (pending_packets.size() != 0 || in_valid || expected_segs.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_period(logic [PERIOD_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        period_us = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [PERIOD_W-1:0] settings[NUM_PHASES];

        settings = '{10'd0, 10'd1, 10'd1023, 10'd1000, 10'($urandom_range(1, 1000)),
                     10'd512, 10'($urandom_range(1023)), 10'd7, 10'd100};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed packets at the reset period
        pending_packets.push_back(24'h000000);
        pending_packets.push_back(24'h555555);
        pending_packets.push_back(24'hAAAAAA);
        pending_packets.push_back(24'hFFFFFF);
        pending_packets.push_back(24'hFFFFFC);
        pending_packets.push_back(24'hFFFFFD);
        pending_packets.push_back(24'hFFFFFE);
        pending_packets.push_back(24'h3FFFFF);
        pending_packets.push_back(24'h7FFFFF);
        pending_packets.push_back(24'hBFFFFF);
        pending_packets.push_back(24'h1B1B1B);
        pending_packets.push_back(24'hE4E4E4);
        pending_packets.push_back(24'h924924);
        pending_packets.push_back(24'h6DB6DB);
        pending_packets.push_back(24'hF0F0F0);
        pending_packets.push_back(24'h0F0F0F);
        pending_packets.push_back(24'hCCCCCC);
        pending_packets.push_back(24'h333333);
        pending_packets.push_back(24'h999999);
        pending_packets.push_back(24'h666666);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p / 3)
                0:
                begin
                    send_idle_pct = 8;
                    recv_stall_pct = 70;
                end
                1:
                begin
                    send_idle_pct = 70;
                    recv_stall_pct = 8;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            write_period(settings[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                pending_packets.push_back(random_packet());
                // hold the sender halfway until the output has fully drained
                if (i == ITEMS_PER_PHASE / 2)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
